// ===== rtl/core/iff_orientation_patcher_defines.svh =====
// Assertion macros for the chunk-stream patcher.
// Each macro checks on the rising edge of clk and stays quiet during reset.
`ifndef IFF_ORIENTATION_PATCHER_DEFINES_SVH
`define IFF_ORIENTATION_PATCHER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define IOP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iop assertion failed");
// Next-cycle implication
`define IOP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("iop assertion failed");
`else
`define IOP_ASSERT_IMP(lbl, ante, cons)
`define IOP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/iop_pkg.sv =====
`default_nettype none

package iop_pkg;

    // Sizing
    localparam int MAX_DEPTH   = 8;
    localparam int OFFSET_BITS = 32;
    localparam int OFS_W       = OFFSET_BITS + 1;
    localparam int NEST_W      = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SUM_W       = ((OFS_W > 32) ? OFS_W : 32) + 1;

    typedef logic [OFS_W-1:0] ofs_t;

    localparam ofs_t OFS_MAX = '1;

    // Chunk ids and FORM types
    localparam logic [31:0] TAG_FORM    = 32'h464f524d;
    localparam logic [31:0] TYPE_PAGE   = 32'h444a5655;
    localparam logic [31:0] TYPE_BUNDLE = 32'h444a564d;
    localparam logic [31:0] TAG_INFO    = 32'h494e464f;
    localparam logic [31:0] TAG_MAGIC   = 32'h41542654;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_TRUNC = 2'd1;
    localparam logic [1:0] ST_DEPTH = 2'd2;

    // Parser modes
    typedef enum logic [3:0] {
        MODE_ID   = 4'b0001,
        MODE_LEN  = 4'b0010,
        MODE_TYPE = 4'b0100,
        MODE_SKIP = 4'b1000
    } mode_t;

    // Round an offset up to even, unless already at the ceiling
    function automatic ofs_t pad_even(ofs_t x);
        ofs_t r;
        r = x;
        if (x[0] && (x != OFS_MAX))
        begin
            r = x + ofs_t'(1);
        end
        return r;
    endfunction

    // Offset plus length, clamped at the ceiling
    function automatic ofs_t sat_add(ofs_t a, logic [31:0] b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b);
        return (sum > SUM_W'(OFS_MAX)) ? OFS_MAX : sum[OFS_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/iff_orientation_patcher.sv =====
// Each result is registered into the output register by its input transfer.
// Throughput: one byte per cycle unless the output register is full and stalled;
// the whole parse state (position, mode, nest stack) updates in a single pass per byte.
// Reset (rst_n low, asynchronous): parser returns to expecting a chunk id at offset 0,
// no FORMs open, no patch pending, status ok. The same state is restored after tlast.
`default_nettype none

`include "iff_orientation_patcher_defines.svh"

module iff_orientation_patcher
    import iop_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]      m_axis_tuser,   // [0] patched, [2:1] status
    output logic            m_axis_tlast    // end_mark
);

    // Parse state
    ofs_t             position_reg, position_next;
    mode_t            mode_reg, mode_next;
    logic [23:0]      hs_reg, hs_next;
    logic [1:0]       fc_reg, fc_next;
    logic             held_form_reg, held_form_next;
    logic             held_info_reg, held_info_next;
    logic [NEST_W-1:0] nest_reg, nest_next;
    ofs_t             skip_end_reg, skip_end_next;
    ofs_t             patch_pos_reg, patch_pos_next;
    logic             pp_reg, pp_next;
    logic [1:0]       sticky_reg, sticky_next;

    // Stack of open FORM ends; link bit k: entry k+1 padded end reaches entry k
    ofs_t             stack_end_reg [MAX_DEPTH];
    logic             stack_link_reg [MAX_DEPTH];

    // Output register
    logic             m_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             patched_reg;
    logic [1:0]       status_reg;
    logic             last_reg;

    logic             acc;
    logic             push;
    logic             patch_hit;
    logic [7:0]       byte_v;
    logic [31:0]      word;
    ofs_t             pos_inc;
    ofs_t             body_start;
    ofs_t             cend_len;
    ofs_t             chunk_start;
    ofs_t             nc_eff;
    logic [NEST_W-1:0] nc_nest;
    logic [IDX_W-1:0] push_idx;
    logic [IDX_W-1:0] below_idx;
    logic             trunc;
    logic [1:0]       status_v;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign acc           = s_axis_tvalid && s_axis_tready;

    // Patch check on the incoming byte
    assign patch_hit = pp_reg && (position_reg == patch_pos_reg) && (s_axis_tdata == 8'd0);
    assign byte_v    = patch_hit ? 8'd1 : s_axis_tdata;
    assign word      = {hs_reg, byte_v};
    assign pos_inc   = sat_add(position_reg, 32'd1);
    assign cend_len  = sat_add(pos_inc, word);
    // First chunk of a FORM body starts on an even offset
    assign body_start = pad_even(pos_inc);

    // Where the next chunk would start, by the header just finished
    always_comb
    begin
        unique case (mode_reg)
            MODE_LEN:  chunk_start = cend_len;
            MODE_TYPE: chunk_start = skip_end_reg;
            MODE_ID:   chunk_start = pos_inc;
            MODE_SKIP: chunk_start = pos_inc;
            default:   chunk_start = pos_inc;
        endcase
    end

    // Close FORMs that end at or before the next chunk start
    always_comb
    begin
        ofs_t               ps;
        ofs_t               sel;
        ofs_t               base;
        logic               any;
        logic [MAX_DEPTH:0] pop;
        logic [MAX_DEPTH-1:0] ge;
        logic [MAX_DEPTH-1:0] ps_ge;
        ps  = pad_even(chunk_start);
        pop = '0;
        for (int k = 0; k < MAX_DEPTH; k++)
        begin
            ge[k]    = pos_inc >= stack_end_reg[k];
            ps_ge[k] = ps >= stack_end_reg[k];
        end
        for (int k = MAX_DEPTH - 1; k >= 0; k--)
        begin
            if (NEST_W'(k + 1) == nest_reg)
            begin
                pop[k] = ps_ge[k] || ge[k];
            end
            else if (NEST_W'(k + 1) < nest_reg)
            begin
                pop[k] = pop[k + 1] && (stack_link_reg[k] || ge[k]);
            end
            else
            begin
                pop[k] = 1'b0;
            end
        end
        nc_nest = nest_reg;
        sel     = ps;
        any     = 1'b0;
        for (int k = MAX_DEPTH - 1; k >= 0; k--)
        begin
            if (pop[k])
            begin
                nc_nest = NEST_W'(k);
                sel     = stack_end_reg[k];
                any     = 1'b1;
            end
        end
        base   = any ? pad_even(sel) : ps;
        nc_eff = (base < pos_inc) ? pos_inc : base;
    end

    // Next parse state
    always_comb
    begin
        logic chunk_go;
        chunk_go       = 1'b0;
        push           = 1'b0;
        position_next  = pos_inc;
        mode_next      = mode_reg;
        hs_next        = hs_reg;
        fc_next        = fc_reg;
        held_form_next = held_form_reg;
        held_info_next = held_info_reg;
        nest_next      = nest_reg;
        skip_end_next  = skip_end_reg;
        patch_pos_next = patch_pos_reg;
        pp_next        = pp_reg;
        sticky_next    = sticky_reg;

        if (pp_reg && (position_reg == patch_pos_reg))
        begin
            pp_next = 1'b0;
        end

        if (mode_reg == MODE_SKIP)
        begin
            if (pos_inc >= skip_end_reg)
            begin
                mode_next = MODE_ID;
                fc_next   = 2'd0;
                hs_next   = '0;
            end
        end
        else if (fc_reg != 2'd3)
        begin
            hs_next = word[23:0];
            fc_next = fc_reg + 2'd1;
        end
        else
        begin
            // Header word complete
            hs_next = '0;
            fc_next = 2'd0;
            unique case (mode_reg)
                MODE_ID:
                begin
                    if (word == TAG_MAGIC)
                    begin
                        chunk_go = 1'b1;
                    end
                    else
                    begin
                        held_form_next = (word == TAG_FORM);
                        held_info_next = (word == TAG_INFO);
                        mode_next      = MODE_LEN;
                    end
                end
                MODE_LEN:
                begin
                    if (held_form_reg)
                    begin
                        skip_end_next = cend_len;
                        mode_next     = MODE_TYPE;
                    end
                    else
                    begin
                        if (held_info_reg && !pp_next)
                        begin
                            patch_pos_next = sat_add(pos_inc, 32'd9);
                            pp_next        = 1'b1;
                        end
                        chunk_go = 1'b1;
                    end
                end
                MODE_TYPE:
                begin
                    if ((word == TYPE_PAGE) || (word == TYPE_BUNDLE))
                    begin
                        if (nest_reg < NEST_W'(MAX_DEPTH))
                        begin
                            // Body start at or past the FORM end: same as skipping to its end
                            if (body_start >= skip_end_reg)
                            begin
                                chunk_go = 1'b1;
                            end
                            else
                            begin
                                push      = 1'b1;
                                nest_next = nest_reg + NEST_W'(1);
                                // Odd body start: step over the pad byte first
                                if (body_start > pos_inc)
                                begin
                                    mode_next     = MODE_SKIP;
                                    skip_end_next = body_start;
                                end
                                else
                                begin
                                    mode_next = MODE_ID;
                                end
                            end
                        end
                        else
                        begin
                            sticky_next = ST_DEPTH;
                            chunk_go    = 1'b1;
                        end
                    end
                    else
                    begin
                        chunk_go = 1'b1;
                    end
                end
                MODE_SKIP:
                begin
                    mode_next = MODE_ID;
                end
                default:
                begin
                    mode_next = MODE_ID;
                end
            endcase
        end

        if (chunk_go)
        begin
            nest_next = nc_nest;
            if (nc_eff > pos_inc)
            begin
                mode_next     = MODE_SKIP;
                skip_end_next = nc_eff;
            end
            else
            begin
                mode_next = MODE_ID;
            end
        end

        // End of file: flag truncation, then back to reset state
        trunc    = ((mode_next == MODE_ID) && (fc_next != 2'd0)) || (mode_next == MODE_LEN)
                   || (mode_next == MODE_TYPE) || pp_next;
        status_v = sticky_next;
        if (s_axis_tlast)
        begin
            if (trunc && (sticky_next == ST_OK))
            begin
                status_v = ST_TRUNC;
            end
            position_next  = '0;
            mode_next      = MODE_ID;
            hs_next        = '0;
            fc_next        = 2'd0;
            held_form_next = 1'b0;
            held_info_next = 1'b0;
            nest_next      = '0;
            skip_end_next  = '0;
            patch_pos_next = '0;
            pp_next        = 1'b0;
            sticky_next    = ST_OK;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            mode_reg      <= MODE_ID;
            hs_reg        <= '0;
            fc_reg        <= 2'd0;
            held_form_reg <= 1'b0;
            held_info_reg <= 1'b0;
            nest_reg      <= '0;
            skip_end_reg  <= '0;
            patch_pos_reg <= '0;
            pp_reg        <= 1'b0;
            sticky_reg    <= ST_OK;
        end
        else if (acc)
        begin
            position_reg  <= position_next;
            mode_reg      <= mode_next;
            hs_reg        <= hs_next;
            fc_reg        <= fc_next;
            held_form_reg <= held_form_next;
            held_info_reg <= held_info_next;
            nest_reg      <= nest_next;
            skip_end_reg  <= skip_end_next;
            patch_pos_reg <= patch_pos_next;
            pp_reg        <= pp_next;
            sticky_reg    <= sticky_next;
        end
    end

    // FORM stack push
    assign push_idx  = nest_reg[IDX_W-1:0];
    assign below_idx = push_idx - IDX_W'(1);

    always_ff @(posedge clk)
    begin
        if (acc && push)
        begin
            stack_end_reg[push_idx] <= skip_end_reg;
            if (nest_reg != '0)
            begin
                stack_link_reg[below_idx] <= pad_even(skip_end_reg) >= stack_end_reg[below_idx];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (acc)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            out_byte_reg <= byte_v;
            patched_reg  <= patch_hit;
            status_reg   <= status_v;
            last_reg     <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {status_reg, patched_reg};
    assign m_axis_tlast  = last_reg;

    // Checks
    `IOP_ASSERT_IMP(a_nest_bound, 1'b1, nest_reg <= NEST_W'(MAX_DEPTH))
    `IOP_ASSERT_IMP(a_skip_ahead, mode_reg == MODE_SKIP, skip_end_reg > position_reg)
    `IOP_ASSERT_IMP(a_patch_one, m_valid_reg && patched_reg, out_byte_reg == 8'd1)
    `IOP_ASSERT_NEXT(a_depth_sticky, acc && !s_axis_tlast && (sticky_reg == ST_DEPTH), sticky_reg == ST_DEPTH)

endmodule

`default_nettype wire

// ===== tb/sv/tb_iff_orientation_patcher.sv =====
`timescale 1ns / 100ps

module tb_iff_orientation_patcher;
    import iop_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       patched;
        logic [1:0] status;
        logic       last;
    } patched_byte_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;    // last
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [2:0] m_axis_tuser;           // [0] patched, [2:1] status
    logic       m_axis_tlast;           // end_mark

    // Byte stream waiting to be sent, and the bytes the block should return
    stream_byte_t  send_q[$];
    patched_byte_t result_q[$];
    stream_byte_t  next_byte;
    patched_byte_t want_byte;

    // File under construction and the offsets of its open FORM length fields
    logic [7:0] file_buf[$];
    int         len_at[$];

    int errors = 0;
    int n_sent = 0;
    int n_files = 0;
    int n_checked = 0;
    int n_patched = 0;
    int n_trunc = 0;
    int n_deep = 0;
    logic calm;

    // Parser shadow state
    ofs_t        pos_r;
    ofs_t        skip_r;
    ofs_t        patch_at;
    ofs_t        form_end [MAX_DEPTH];
    mode_t       mode_r;
    logic [31:0] hdr_r;
    logic [31:0] held_r;
    logic [3:0]  fcnt_r;
    int          depth_r;
    logic        patch_armed;
    logic [1:0]  sticky_r;

    iff_orientation_patcher uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // No random idling on either side for a stretch in the middle of the run
    assign calm = (n_sent >= 500) && (n_sent < 800);

    function automatic ofs_t even_up(ofs_t x);
        if (x[0] && (x != OFS_MAX))
        begin
            return x + 1'b1;
        end
        return x;
    endfunction

    // Offset plus 32-bit length, clamped to the largest offset
    function automatic ofs_t clamp_add(ofs_t a, logic [31:0] b);
        logic [OFS_W+32:0] s;
        s = a;
        s = s + b;
        if (s > OFS_MAX)
        begin
            return OFS_MAX;
        end
        return s[OFS_W-1:0];
    endfunction

    task automatic clear_parser();
        pos_r = '0;
        skip_r = '0;
        patch_at = '0;
        mode_r = MODE_ID;
        hdr_r = '0;
        held_r = '0;
        fcnt_r = '0;
        depth_r = 0;
        patch_armed = 1'b0;
        sticky_r = ST_OK;
    endtask

    // Schedule the next header; closes every FORM whose end has been reached
    task automatic seek_chunk(input ofs_t start);
        ofs_t eff;
        eff = even_up(start);
        if (eff < pos_r)
        begin
            eff = pos_r;
        end
        while (depth_r > 0 && eff >= form_end[depth_r-1])
        begin
            depth_r = depth_r - 1;
            eff = even_up(form_end[depth_r]);
            if (eff < pos_r)
            begin
                eff = pos_r;
            end
        end
        fcnt_r = '0;
        hdr_r = '0;
        if (eff > pos_r)
        begin
            mode_r = MODE_SKIP;
            skip_r = eff;
        end
        else
        begin
            mode_r = MODE_ID;
        end
    endtask

    // Advance the shadow parser by one byte and queue the expected output
    task automatic parse_byte(input logic [7:0] din, input logic lin);
        logic [7:0]    b;
        logic          hit;
        logic [31:0]   word;
        ofs_t          cend;
        logic          cut;
        patched_byte_t r;
        b = din;
        hit = 1'b0;
        if (patch_armed && pos_r == patch_at)
        begin
            patch_armed = 1'b0;
            if (b == 8'h00)
            begin
                b = 8'h01;
                hit = 1'b1;
            end
        end
        pos_r = clamp_add(pos_r, 32'd1);

        if (mode_r == MODE_SKIP)
        begin
            if (pos_r >= skip_r)
            begin
                mode_r = MODE_ID;
                fcnt_r = '0;
                hdr_r = '0;
            end
        end
        else
        begin
            hdr_r = {hdr_r[23:0], b};
            fcnt_r = fcnt_r + 1'b1;
            if (fcnt_r >= 4)
            begin
                word = hdr_r;
                fcnt_r = '0;
                hdr_r = '0;
                case (mode_r)
                    MODE_ID:
                    begin
                        if (word == TAG_MAGIC)
                        begin
                            seek_chunk(pos_r);
                        end
                        else
                        begin
                            held_r = word;
                            mode_r = MODE_LEN;
                        end
                    end
                    MODE_LEN:
                    begin
                        cend = clamp_add(pos_r, word);
                        if (held_r == TAG_FORM)
                        begin
                            skip_r = cend;
                            mode_r = MODE_TYPE;
                        end
                        else
                        begin
                            // a second INFO while one patch is pending is ignored
                            if (held_r == TAG_INFO && !patch_armed)
                            begin
                                patch_at = clamp_add(pos_r, 32'd9);
                                patch_armed = 1'b1;
                            end
                            seek_chunk(cend);
                        end
                    end
                    default:
                    begin
                        cend = skip_r;
                        if (word == TYPE_PAGE || word == TYPE_BUNDLE)
                        begin
                            if (depth_r < MAX_DEPTH)
                            begin
                                form_end[depth_r] = cend;
                                depth_r = depth_r + 1;
                                seek_chunk(pos_r);
                            end
                            else
                            begin
                                sticky_r = ST_DEPTH;
                                seek_chunk(cend);
                            end
                        end
                        else
                        begin
                            seek_chunk(cend);
                        end
                    end
                endcase
            end
        end

        if (lin)
        begin
            cut = (mode_r == MODE_ID && fcnt_r != 0) || mode_r == MODE_LEN ||
                  mode_r == MODE_TYPE || patch_armed;
            if (cut && sticky_r == ST_OK)
            begin
                sticky_r = ST_TRUNC;
            end
        end

        r.data = b;
        r.patched = hit;
        r.status = sticky_r;
        r.last = lin;
        result_q.push_back(r);
        if (lin)
        begin
            clear_parser();
        end
    endtask

    // File builders
    task automatic put_word(input logic [31:0] w);
        file_buf.push_back(w[31:24]);
        file_buf.push_back(w[23:16]);
        file_buf.push_back(w[15:8]);
        file_buf.push_back(w[7:0]);
    endtask

    task automatic open_form(input logic [31:0] kind);
        put_word(TAG_FORM);
        len_at.push_back(file_buf.size());
        put_word(32'd0);
        put_word(kind);
    endtask

    // Fill in the length of the innermost open FORM, now and then off by a few
    task automatic close_form();
        int          at;
        logic [31:0] n;
        at = len_at.pop_back();
        n = file_buf.size() - at - 4;
        if ($urandom_range(99) < 8)
        begin
            n = n + $urandom_range(6) - 3;
        end
        file_buf[at]   = n[31:24];
        file_buf[at+1] = n[23:16];
        file_buf[at+2] = n[15:8];
        file_buf[at+3] = n[7:0];
    endtask

    function automatic logic [31:0] pick_kind();
        int r;
        r = $urandom_range(9);
        if (r < 4)
        begin
            return TYPE_PAGE;
        end
        if (r < 8)
        begin
            return TYPE_BUNDLE;
        end
        return $urandom;
    endfunction

    // Plain chunk; zero_at9 clears the byte that an INFO patch targets
    task automatic put_leaf(input logic [31:0] id, input int n, input logic zero_at9);
        put_word(id);
        put_word(n);
        for (int i = 0; i < n; i++)
        begin
            file_buf.push_back((i == 9 && zero_at9) ? 8'h00 : 8'($urandom_range(255)));
        end
        if (n % 2)
        begin
            file_buf.push_back(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00);
        end
    endtask

    task automatic send_file();
        stream_byte_t sb;
        for (int i = 0; i < file_buf.size(); i++)
        begin
            sb.data = file_buf[i];
            sb.last = (i == file_buf.size() - 1);
            send_q.push_back(sb);
        end
        n_files = n_files + 1;
        file_buf.delete();
    endtask

    // One random file: mostly well-formed nests, with noise, bad lengths and cut-offs
    task automatic build_file();
        int r;
        int cut;
        file_buf.delete();
        len_at.delete();
        if ($urandom_range(19) == 0)
        begin
            repeat ($urandom_range(1, 24)) file_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(2) == 0)
            begin
                put_word(TAG_MAGIC);
            end
            open_form(pick_kind());
            repeat ($urandom_range(2, 10))
            begin
                r = $urandom_range(99);
                if (r < 5)
                begin
                    // nesting beyond the supported depth
                    repeat (MAX_DEPTH + 1 + $urandom_range(1))
                        open_form(($urandom_range(1) == 0) ? TYPE_PAGE : TYPE_BUNDLE);
                end
                else if (r < 22)
                begin
                    open_form(pick_kind());
                end
                else if (r < 36)
                begin
                    if (len_at.size() > 0)
                    begin
                        close_form();
                    end
                end
                else if (r < 58)
                begin
                    put_leaf(TAG_INFO, $urandom_range(14), $urandom_range(9) < 7);
                end
                else if (r < 64)
                begin
                    put_word(TAG_MAGIC);
                end
                else if (r < 68)
                begin
                    put_leaf($urandom, $urandom_range(20, 40), 1'b0);
                end
                else
                begin
                    put_leaf($urandom, $urandom_range(12), 1'b0);
                end
            end
            while (len_at.size() > 0)
            begin
                close_form();
            end
        end
        if ($urandom_range(99) < 6)
        begin
            file_buf[$urandom_range(file_buf.size() - 1)] = 8'($urandom_range(255));
        end
        if ($urandom_range(99) < 12)
        begin
            cut = $urandom_range(1, file_buf.size());
            while (file_buf.size() > cut)
            begin
                file_buf.pop_back();
            end
        end
        send_file();
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        clear_parser();

        // one lone zero byte: file ends inside a chunk id
        file_buf.push_back(8'h00);
        send_file();
        // magic then one byte of an id
        put_word(TAG_MAGIC);
        file_buf.push_back(8'hff);
        send_file();
        // empty INFO: patch lands past the chunk and the file ends before it
        put_word(TAG_INFO);
        put_word(32'd0);
        put_word(32'h00ff_0000);
        send_file();

        while (send_q.size() < 1470)
        begin
            build_file();
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (send_q.size() != 0 || s_axis_tvalid)
        begin
            @(posedge clk);
        end
        while (result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        $display("covered %0d files, %0d bytes checked, %0d bytes patched", n_files,
                 n_checked, n_patched);
        $display("files flagged as cut short: %0d, files flagged too deep: %0d", n_trunc,
                 n_deep);
        if (errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout waiting for output transfers");
        $display("status: fail");
        $finish;
    end

    // Driver: predicts on each accepted transfer, then offers the next byte
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                parse_byte(s_axis_tdata, s_axis_tlast);
                n_sent <= n_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_q.size() != 0 && (calm || $urandom_range(99) >= 13))
                begin
                    next_byte = send_q.pop_front();
                    s_axis_tdata  <= next_byte.data;
                    s_axis_tlast  <= next_byte.last;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            errors = errors + 1;
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Monitor: compares each output transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_q.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t unexpected output transfer: expected none, actual data %0h",
                             $time, m_axis_tdata);
                end
                else
                begin
                    want_byte = result_q.pop_front();
                    n_checked = n_checked + 1;
                    n_patched = n_patched + want_byte.patched;
                    if (want_byte.last && want_byte.status == ST_TRUNC)
                    begin
                        n_trunc = n_trunc + 1;
                    end
                    if (want_byte.last && want_byte.status == ST_DEPTH)
                    begin
                        n_deep = n_deep + 1;
                    end
                    check_field("out_byte", want_byte.data, m_axis_tdata);
                    check_field("patched", 8'(want_byte.patched), 8'(m_axis_tuser[0]));
                    check_field("status", 8'(want_byte.status), 8'(m_axis_tuser[2:1]));
                    check_field("end_mark", 8'(want_byte.last), 8'(m_axis_tlast));
                end
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 13);
        end
    end

endmodule
